### rtl/gmg_pkg.sv
// ----------------------------------------------------------------------------
// gmg_pkg: shared types and constants of the mean gradient unit
// Field widths, register codes and the item flags that travel through the
// queue between the pixel front end and the root/accumulate back end.
// ----------------------------------------------------------------------------
package gmg_pkg;

   localparam int PIX_W  = 8;
   localparam int REG_W  = 12;
   localparam int MEAN_W = 16;
   localparam int SUM_W  = 38;
   localparam int ENERGY_W = 16;
   localparam int ROOT_W = 16;
   localparam int RAD_W  = 2 * ROOT_W;
   localparam int REM_W  = ROOT_W + 3;

   localparam int DEF_MAX_WIDTH  = 2048;
   localparam int DEF_MAX_HEIGHT = 2048;

   localparam logic [REG_W-1:0] WIDTH_RESET  = 12'd640;
   localparam logic [REG_W-1:0] HEIGHT_RESET = 12'd480;

   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT = 1'b1;

   localparam int QUEUE_DEPTH = 8;
   localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic term;   // the pixel closes a 2x2 window and adds a root term
      logic last;   // the pixel is the last of its frame
   } item_flags_type;

   localparam int FLAG_W = $bits(item_flags_type);

endpackage

### rtl/gmg_front.sv
// ----------------------------------------------------------------------------
// gmg_front: pixel intake and gradient energy
// Tracks the raster position, keeps the previous row in a line store and
// forms half the squared gradient of each closed window.
// ----------------------------------------------------------------------------
module gmg_front #(
   parameter int MAX_WIDTH  = gmg_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = gmg_pkg::DEF_MAX_HEIGHT,
   parameter int COL_W = $clog2(MAX_WIDTH),
   parameter int ROW_W = $clog2(MAX_HEIGHT),
   parameter int NW    = COL_W + ROW_W
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           push,
   input  logic [gmg_pkg::PIX_W-1:0]      pixel,
   output logic                           full,
   input  logic [gmg_pkg::REG_W-1:0]      width_reg,
   input  logic [gmg_pkg::REG_W-1:0]      height_reg,
   input  logic [gmg_pkg::QCNT_W-1:0]     q_count,
   output logic                           out_push,
   output gmg_pkg::item_flags_type        out_flags,
   output logic [gmg_pkg::ENERGY_W-1:0]   out_energy,
   output logic [NW-1:0]                  out_n
);
   import gmg_pkg::*;

   logic [PIX_W-1:0] row_mem [MAX_WIDTH];
   logic [PIX_W-1:0] up_ff;

   logic [COL_W-1:0] col_ff;
   logic [ROW_W-1:0] row_ff;
   logic [COL_W-1:0] w_m1;
   logic [ROW_W-1:0] h_m1;
   logic             accept;
   logic [QCNT_W:0]  occupancy;

   logic             vb_ff, vc_ff;
   item_flags_type   flags_b_ff, flags_c_ff;
   logic [NW-1:0]    n_b_ff, n_c_ff;
   logic [PIX_W-1:0] pix_b_ff;
   logic [PIX_W-1:0] ul_ff, left_ff;
   logic [15:0]      sqx_ff, sqy_ff;

   logic signed [PIX_W:0]     dx, dy;
   logic signed [2*PIX_W+1:0] dx2, dy2;
   logic [16:0]               energy_sum;

   // Clamp the configured sizes; keep them as last index values.
   always_comb begin
      if (width_reg < 12'd2) begin
         w_m1 = COL_W'(1);
      end else if (32'(width_reg) > MAX_WIDTH) begin
         w_m1 = COL_W'(MAX_WIDTH - 1);
      end else begin
         w_m1 = COL_W'(width_reg - 12'd1);
      end
      if (height_reg < 12'd2) begin
         h_m1 = ROW_W'(1);
      end else if (32'(height_reg) > MAX_HEIGHT) begin
         h_m1 = ROW_W'(MAX_HEIGHT - 1);
      end else begin
         h_m1 = ROW_W'(height_reg - 12'd1);
      end
   end

   // Items in the two energy stages count against the queue space.
   assign occupancy = {1'b0, q_count} + (QCNT_W+1)'(vb_ff) + (QCNT_W+1)'(vc_ff);
   assign full      = occupancy >= (QCNT_W+1)'(QUEUE_DEPTH);
   assign accept    = push & ~full;

   // Line store: the old entry is read out as the new pixel replaces it.
   always_ff @(posedge clock) begin
      if (accept) begin
         up_ff          <= row_mem[col_ff];
         row_mem[col_ff] <= pixel;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (accept) begin
         if (col_ff >= w_m1) begin
            col_ff <= '0;
            if (row_ff >= h_m1) begin
               row_ff <= '0;
            end else begin
               row_ff <= row_ff + ROW_W'(1);
            end
         end else begin
            col_ff <= col_ff + COL_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      pix_b_ff        <= pixel;
      flags_b_ff.term <= (row_ff != '0) && (col_ff != '0);
      flags_b_ff.last <= (col_ff >= w_m1) && (row_ff >= h_m1);
      n_b_ff          <= NW'(h_m1) * NW'(w_m1);
   end

   assign dx  = $signed({1'b0, up_ff})   - $signed({1'b0, ul_ff});
   assign dy  = $signed({1'b0, left_ff}) - $signed({1'b0, ul_ff});
   assign dx2 = dx * dx;
   assign dy2 = dy * dy;

   always_ff @(posedge clock) begin
      if (reset) begin
         vb_ff   <= 1'b0;
         vc_ff   <= 1'b0;
         ul_ff   <= '0;
         left_ff <= '0;
      end else begin
         vb_ff <= accept;
         vc_ff <= vb_ff;
         if (vb_ff) begin
            ul_ff   <= up_ff;
            left_ff <= pix_b_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      sqx_ff     <= dx2[15:0];
      sqy_ff     <= dy2[15:0];
      flags_c_ff <= flags_b_ff;
      n_c_ff     <= n_b_ff;
   end

   assign energy_sum = {1'b0, sqx_ff} + {1'b0, sqy_ff};
   assign out_push   = vc_ff;
   assign out_flags  = flags_c_ff;
   assign out_energy = energy_sum[16:1];
   assign out_n      = n_c_ff;

endmodule

### rtl/gmg_queue.sv
// ----------------------------------------------------------------------------
// gmg_queue: short first-in first-out queue
// Decouples the pixel front end from the root and accumulate back end.
// ----------------------------------------------------------------------------
module gmg_queue #(
   parameter int DATA_W = 8
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   input  logic [DATA_W-1:0]           push_data,
   input  logic                        pop,
   output logic [DATA_W-1:0]           pop_data,
   output logic                        empty,
   output logic [gmg_pkg::QCNT_W-1:0]  count
);
   import gmg_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);

   logic [DATA_W-1:0] slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ff, rd_ff;
   logic [QCNT_W-1:0] count_ff;

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         if (push) begin
            wr_ff <= (wr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ff + PTR_W'(1);
         end
         if (pop) begin
            rd_ff <= (rd_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ff + PTR_W'(1);
         end
         count_ff <= count_ff + QCNT_W'(push) - QCNT_W'(pop);
      end
   end

   assign pop_data = slot_ff[rd_ff];
   assign empty    = (count_ff == '0);
   assign count    = count_ff;

endmodule

### rtl/gmg_sqrt.sv
// ----------------------------------------------------------------------------
// gmg_sqrt: pipelined integer square root
// One root bit per stage, digit by digit, with a tag carried alongside.
// ----------------------------------------------------------------------------
module gmg_sqrt #(
   parameter int TAG_W = 2
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   input  logic [gmg_pkg::RAD_W-1:0]   in_radicand,
   input  logic [TAG_W-1:0]            in_tag,
   output logic                        out_valid,
   output logic [gmg_pkg::ROOT_W-1:0]  out_root,
   output logic [TAG_W-1:0]            out_tag
);
   import gmg_pkg::*;

   logic              vld_ff  [ROOT_W];
   logic [REM_W-1:0]  rem_ff  [ROOT_W];
   logic [ROOT_W-1:0] root_ff [ROOT_W];
   logic [RAD_W-1:0]  rad_ff  [ROOT_W];
   logic [TAG_W-1:0]  tag_ff  [ROOT_W];

   genvar g;
   for (g = 0; g < ROOT_W; g++) begin : g_stage
      logic              vld_src;
      logic [REM_W-1:0]  rem_src;
      logic [ROOT_W-1:0] root_src;
      logic [RAD_W-1:0]  rad_src;
      logic [TAG_W-1:0]  tag_src;
      logic [REM_W-1:0]  shifted, trial, rem_in;
      logic [ROOT_W-1:0] root_in;

      if (g == 0) begin : g_head
         assign vld_src  = in_valid;
         assign rem_src  = '0;
         assign root_src = '0;
         assign rad_src  = in_radicand;
         assign tag_src  = in_tag;
      end else begin : g_body
         assign vld_src  = vld_ff[g-1];
         assign rem_src  = rem_ff[g-1];
         assign root_src = root_ff[g-1];
         assign rad_src  = rad_ff[g-1];
         assign tag_src  = tag_ff[g-1];
      end

      always_comb begin
         shifted = {rem_src[REM_W-3:0], rad_src[RAD_W-1 -: 2]};
         trial   = REM_W'({root_src, 2'b01});
         if (shifted >= trial) begin
            rem_in  = shifted - trial;
            root_in = {root_src[ROOT_W-2:0], 1'b1};
         end else begin
            rem_in  = shifted;
            root_in = {root_src[ROOT_W-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[g] <= 1'b0;
         end else begin
            vld_ff[g] <= vld_src;
         end
      end

      always_ff @(posedge clock) begin
         rem_ff[g]  <= rem_in;
         root_ff[g] <= root_in;
         rad_ff[g]  <= {rad_src[RAD_W-3:0], 2'b00};
         tag_ff[g]  <= tag_src;
      end
   end

   assign out_valid = vld_ff[ROOT_W-1];
   assign out_root  = root_ff[ROOT_W-1];
   assign out_tag   = tag_ff[ROOT_W-1];

endmodule

### rtl/gmg_back.sv
// ----------------------------------------------------------------------------
// gmg_back: root, accumulation and frame mean
// Drains the queue through the root pipeline, sums the roots and divides
// the frame total by the window count, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module gmg_back #(
   parameter int NW = 22
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         q_empty,
   input  gmg_pkg::item_flags_type      q_flags,
   input  logic [gmg_pkg::ENERGY_W-1:0] q_energy,
   input  logic [NW-1:0]                q_n,
   output logic                         q_pop,
   output logic                         rsp_empty,
   input  logic                         rsp_pop,
   output logic [gmg_pkg::MEAN_W-1:0]   rsp_mean,
   output logic [gmg_pkg::SUM_W-1:0]    rsp_sum
);
   import gmg_pkg::*;

   localparam int TAG_W = FLAG_W + NW;
   localparam int CNT_W = $clog2(SUM_W);

   typedef enum logic [1:0] {ST_IDLE, ST_DIVIDE, ST_HOLD} state_type;

   state_type         state_ff;
   logic              pending_ff;
   logic [SUM_W-1:0]  sum_ff, dq_ff, total_ff;
   logic [NW-1:0]     rem_ff, div_n_ff;
   logic [CNT_W-1:0]  cnt_ff;
   logic [MEAN_W-1:0] mean_ff;

   logic              s_valid;
   logic [ROOT_W-1:0] s_root;
   logic [TAG_W-1:0]  s_tag;
   item_flags_type    s_flags;
   logic [NW-1:0]     s_n;
   logic [SUM_W-1:0]  total;
   logic [NW:0]       rem_shift;
   logic              ge;
   logic [NW-1:0]     rem_in;
   logic [SUM_W-1:0]  dq_in;
   logic [MEAN_W-1:0] mean_in;

   // Only one frame end may be in the back end at a time.
   assign q_pop = ~q_empty & (~q_flags.last | ~pending_ff);

   gmg_sqrt #(.TAG_W(TAG_W)) u_sqrt (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (q_pop),
      .in_radicand ({q_energy, (RAD_W-ENERGY_W)'(0)}),
      .in_tag      ({q_flags, q_n}),
      .out_valid   (s_valid),
      .out_root    (s_root),
      .out_tag     (s_tag)
   );

   assign s_flags = item_flags_type'(s_tag[TAG_W-1 -: FLAG_W]);
   assign s_n     = s_tag[NW-1:0];
   assign total   = s_flags.term ? sum_ff + SUM_W'(s_root) : sum_ff;

   always_comb begin
      rem_shift = {rem_ff, dq_ff[SUM_W-1]};
      ge        = rem_shift >= {1'b0, div_n_ff};
      rem_in    = ge ? NW'(rem_shift - {1'b0, div_n_ff}) : rem_shift[NW-1:0];
      dq_in     = {dq_ff[SUM_W-2:0], ge};
      mean_in   = (|dq_in[SUM_W-1:MEAN_W]) ? '1 : dq_in[MEAN_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         pending_ff <= 1'b0;
         sum_ff     <= '0;
      end else begin
         if (q_pop && q_flags.last) begin
            pending_ff <= 1'b1;
         end
         if (s_valid) begin
            sum_ff <= s_flags.last ? '0 : total;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (s_valid && s_flags.last) begin
                  dq_ff    <= total;
                  total_ff <= total;
                  rem_ff   <= '0;
                  div_n_ff <= s_n;
                  cnt_ff   <= '0;
                  state_ff <= ST_DIVIDE;
               end
            end
            ST_DIVIDE: begin
               dq_ff  <= dq_in;
               rem_ff <= rem_in;
               cnt_ff <= cnt_ff + CNT_W'(1);
               if (cnt_ff == CNT_W'(SUM_W - 1)) begin
                  mean_ff  <= mean_in;
                  state_ff <= ST_HOLD;
               end
            end
            ST_HOLD: begin
               if (rsp_pop) begin
                  pending_ff <= 1'b0;
                  state_ff   <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_empty = (state_ff != ST_HOLD);
   assign rsp_mean  = mean_ff;
   assign rsp_sum   = total_ff;

endmodule

### rtl/gray_mean_gradient_unit.sv
// ----------------------------------------------------------------------------
// gray_mean_gradient_unit: grey-level mean gradient sharpness of a frame
// Sums truncated Q8 gradient roots over a raster frame and reports the sum
// and its Q8.8 mean after the last pixel.
// ----------------------------------------------------------------------------
// Usage. Pixels enter one per beat on the req_ queue port (req_push while
// req_full is low). The frame size comes from two registers written through
// csr_write/csr_index/csr_data while the unit is idle; sizes outside 2 to the
// maximum are clamped. One result beat per frame appears on the rsp_ queue
// port (rsp_empty low, taken with rsp_pop).
// Throughput: one pixel per cycle while req_full is low. The line store is
// read and written in the same cycle, the energy and root paths are
// pipelined, and the root pipeline drains the internal queue at one item
// per cycle, but a frame end waits while a result is pending. After the edge
// that takes the last pixel of a frame, it passes the energy registers into
// the queue, the 16 root stages fed straight from the queue head, the
// accumulate register and a bit-serial divide to reach the rsp_ ports.
// Stall: while a result waits to be taken the next frame keeps flowing; its
// last pixel waits in the queue, so req_full rises once the queue fills.
// Reset clears raster and queue counters, held pixels, sum and all valid flags
// and loads the registers with 640 by 480. The line store is not cleared.
// ----------------------------------------------------------------------------
module gray_mean_gradient_unit #(
   parameter int MAX_WIDTH  = gmg_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = gmg_pkg::DEF_MAX_HEIGHT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_push,
   output logic                           req_full,
   input  logic [gmg_pkg::PIX_W-1:0]      req_pixel,
   output logic                           rsp_empty,
   input  logic                           rsp_pop,
   output logic [gmg_pkg::MEAN_W-1:0]     rsp_mean_gradient,
   output logic [gmg_pkg::SUM_W-1:0]      rsp_gradient_sum,
   input  logic                           csr_write,
   input  logic [gmg_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [gmg_pkg::REG_W-1:0]      csr_data
);
   import gmg_pkg::*;

   localparam int COL_W = $clog2(MAX_WIDTH);
   localparam int ROW_W = $clog2(MAX_HEIGHT);
   localparam int NW    = COL_W + ROW_W;
   localparam int QD_W  = FLAG_W + ENERGY_W + NW;

   logic [REG_W-1:0]    width_ff, height_ff;

   logic                f_push;
   item_flags_type      f_flags;
   logic [ENERGY_W-1:0] f_energy;
   logic [NW-1:0]       f_n;

   logic [QD_W-1:0]     q_data;
   logic                q_empty, q_pop;
   logic [QCNT_W-1:0]   q_count;
   item_flags_type      q_flags;
   logic [ENERGY_W-1:0] q_energy;
   logic [NW-1:0]       q_n;

   // Configuration registers; writes take effect at once.
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_IMAGE_WIDTH:  width_ff  <= csr_data;
            CSR_IMAGE_HEIGHT: height_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // Front end: raster tracking, line store and half squared gradient.
   gmg_front #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT),
      .COL_W      (COL_W),
      .ROW_W      (ROW_W),
      .NW         (NW)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .push       (req_push),
      .pixel      (req_pixel),
      .full       (req_full),
      .width_reg  (width_ff),
      .height_reg (height_ff),
      .q_count    (q_count),
      .out_push   (f_push),
      .out_flags  (f_flags),
      .out_energy (f_energy),
      .out_n      (f_n)
   );

   // The front end never pushes into a full queue: its intake counts the
   // items still in its own stages against the free slots.
   gmg_queue #(.DATA_W(QD_W)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (f_push),
      .push_data ({f_flags, f_energy, f_n}),
      .pop       (q_pop),
      .pop_data  (q_data),
      .empty     (q_empty),
      .count     (q_count)
   );

   assign q_flags  = item_flags_type'(q_data[QD_W-1 -: FLAG_W]);
   assign q_energy = q_data[NW +: ENERGY_W];
   assign q_n      = q_data[NW-1:0];

   // Back end: square root, running sum, divide and the result register.
   gmg_back #(.NW(NW)) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .q_flags   (q_flags),
      .q_energy  (q_energy),
      .q_n       (q_n),
      .q_pop     (q_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_mean  (rsp_mean_gradient),
      .rsp_sum   (rsp_gradient_sum)
   );

endmodule

### tb/tb_gray_mean_gradient_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_gray_mean_gradient_unit: self-checking bench for the mean gradient unit
// Streams grey frames through the pixel queue, predicts the per-frame root
// sum and Q8.8 mean with an independent bit-exact tracker, and compares
// every result beat against the oldest expected one. Both queue sides idle
// and stall at random; frame sizes change only while the unit is idle.
// ----------------------------------------------------------------------------
module tb_gray_mean_gradient_unit;

   import gmg_pkg::*;

   localparam int MAX_W         = DEF_MAX_WIDTH;
   localparam int MAX_H         = DEF_MAX_HEIGHT;
   localparam int SETTLE_CYCLES = 100;
   localparam int RANDOM_PIXELS = 480;
   localparam int RANDOM_FRAMES = 20;
   localparam int REPORT_LIMIT  = 10;

   // Pixel textures used to shape random frames.
   typedef enum int {TEX_NOISE, TEX_BINARY, TEX_SMOOTH, TEX_FLAT} texture_type;

   typedef struct packed {
      logic [MEAN_W-1:0] mean;
      logic [SUM_W-1:0]  sum;
   } frame_stats_type;

   // One row of the directed table. Where typed is set, the row is the last
   // pixel of a frame whose result is written out by hand.
   typedef struct packed {
      logic [PIX_W-1:0]  pixel;
      logic              typed;
      logic [MEAN_W-1:0] mean;
      logic [SUM_W-1:0]  sum;
   } pixel_row_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_push = 1'b0;
   logic                 req_full;
   logic [PIX_W-1:0]     req_pixel = '0;
   logic                 rsp_empty;
   logic                 rsp_pop = 1'b0;
   logic [MEAN_W-1:0]    rsp_mean_gradient;
   logic [SUM_W-1:0]     rsp_gradient_sum;
   logic                 csr_write = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = CSR_IMAGE_WIDTH;
   logic [REG_W-1:0]     csr_data = '0;

   gray_mean_gradient_unit dut (
      .clock             (clock),
      .reset             (reset),
      .req_push          (req_push),
      .req_full          (req_full),
      .req_pixel         (req_pixel),
      .rsp_empty         (rsp_empty),
      .rsp_pop           (rsp_pop),
      .rsp_mean_gradient (rsp_mean_gradient),
      .rsp_gradient_sum  (rsp_gradient_sum),
      .csr_write         (csr_write),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Give up well after the slowest legal run: every pixel waiting out the
   // longest gap, plus the frame results and the idle pauses.
   initial begin
      #10_000_000;
      $display("FAILURE");
      $finish;
   end

   // ---------------------------------------------------------------------
   // Tracker state. It mirrors what the unit must hold: the register
   // values as written, one row of pixels, the two held pixels of the
   // 2x2 window, the raster position and the running root sum.
   // ---------------------------------------------------------------------
   logic [REG_W-1:0]  cfg_width  = WIDTH_RESET;
   logic [REG_W-1:0]  cfg_height = HEIGHT_RESET;
   logic [PIX_W-1:0]  line_buf [MAX_W];
   logic [PIX_W-1:0]  held_upper_left = '0;
   logic [PIX_W-1:0]  held_left = '0;
   int unsigned       col_pos = 0;
   int unsigned       row_pos = 0;
   logic [SUM_W-1:0]  root_total = '0;

   frame_stats_type   frame_stats_due [$];
   bit                idle_on = 1'b1;
   int unsigned       mismatches = 0;
   int unsigned       pixels_sent = 0;

   initial begin
      for (int i = 0; i < MAX_W; i++)
         line_buf[i] = '0;
   end

   function automatic int unsigned clamp_dim(input logic [REG_W-1:0] v, input int unsigned hi);
      if (v < 2)
         return 2;
      if (v > hi)
         return hi;
      return v;
   endfunction

   // floor(sqrt(energy) * 256): the root of energy * 2^16, bit by bit.
   function automatic logic [ROOT_W-1:0] q8_root(input int unsigned energy);
      longint unsigned radicand;
      longint unsigned trial;
      logic [ROOT_W-1:0] root;
      radicand = longint'(energy) << 16;
      root = '0;
      for (int b = ROOT_W - 1; b >= 0; b--) begin
         trial = root | (longint'(1) << b);
         if (trial * trial <= radicand)
            root = trial[ROOT_W-1:0];
      end
      return root;
   endfunction

   // Account for one accepted pixel. The term of window (j,i) is formed when
   // pixel (j+1,i+1) arrives; the frame result falls due on its last pixel.
   function automatic void track_pixel(input logic [PIX_W-1:0] pix, output bit done,
                                       output frame_stats_type stats);
      int unsigned w;
      int unsigned h;
      int unsigned c;
      logic [PIX_W-1:0] above;
      int dx;
      int dy;
      int unsigned energy;
      longint unsigned windows;
      longint unsigned quotient;
      w = clamp_dim(cfg_width, MAX_W);
      h = clamp_dim(cfg_height, MAX_H);
      c = col_pos;
      above = line_buf[c];
      done = 1'b0;
      stats = '0;
      if (row_pos >= 1 && c >= 1) begin
         dx = int'(above) - int'(held_upper_left);
         dy = int'(held_left) - int'(held_upper_left);
         energy = (dx * dx + dy * dy) / 2;
         root_total = root_total + SUM_W'(q8_root(energy));
      end
      held_upper_left = above;
      held_left = pix;
      line_buf[c] = pix;
      if (c + 1 >= w) begin
         col_pos = 0;
         if (row_pos + 1 >= h) begin
            windows = longint'(h - 1) * longint'(w - 1);
            quotient = longint'(root_total) / windows;
            stats.mean = (quotient > 64'hFFFF) ? 16'hFFFF : quotient[MEAN_W-1:0];
            stats.sum = root_total;
            done = 1'b1;
            row_pos = 0;
            root_total = '0;
         end else begin
            row_pos = row_pos + 1;
         end
      end else begin
         col_pos = c + 1;
      end
   endfunction

   function automatic void note_mismatch(input string msg);
      mismatches++;
      if (mismatches <= REPORT_LIMIT)
         $display("mismatch: %s", msg);
   endfunction

   function automatic logic [PIX_W-1:0] pick_pixel(input texture_type tex,
                                                   input logic [PIX_W-1:0] prev);
      int level;
      case (tex)
         TEX_NOISE: begin
            return PIX_W'($urandom_range(0, 255));
         end
         TEX_BINARY: begin
            return ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
         end
         TEX_SMOOTH: begin
            level = int'(prev) + int'($urandom_range(0, 6)) - 3;
            if (level < 0)
               level = 0;
            if (level > 255)
               level = 255;
            return PIX_W'(level);
         end
         default: begin
            return prev;
         end
      endcase
   endfunction

   // ---------------------------------------------------------------------
   // Pixel side. Each call starts at a falling edge and returns at the
   // falling edge after its beat. req_push stays high across back-to-back
   // beats, so it is never lowered and raised within one step.
   // ---------------------------------------------------------------------
   task automatic send_pixel(input logic [PIX_W-1:0] pix, input logic typed,
                             input frame_stats_type typed_stats);
      int gap;
      bit done;
      frame_stats_type stats;
      gap = idle_on ? $urandom_range(0, 10) : 0;
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_push  <= 1'b1;
      req_pixel <= pix;
      do @(posedge clock); while (req_full);
      track_pixel(pix, done, stats);
      if (done)
         frame_stats_due.push_back(typed ? typed_stats : stats);
      pixels_sent++;
      @(negedge clock);
   endtask

   task automatic send_frame(input texture_type tex);
      int unsigned count;
      logic [PIX_W-1:0] pix;
      count = clamp_dim(cfg_width, MAX_W) * clamp_dim(cfg_height, MAX_H);
      pix = PIX_W'($urandom_range(0, 255));
      repeat (count) begin
         pix = pick_pixel(tex, pix);
         send_pixel(pix, 1'b0, '0);
      end
   endtask

   // Stop pushing, let every due frame result come out, then give the
   // back end time to go quiet before anything else happens.
   task automatic wait_idle();
      req_push <= 1'b0;
      while (frame_stats_due.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Register writes, one beat each, only ever called while the unit is idle.
   // When both are written the enable stays high over both beats.
   task automatic program_size(input bit set_w, input logic [REG_W-1:0] w_val,
                               input bit set_h, input logic [REG_W-1:0] h_val);
      if (set_w) begin
         csr_write <= 1'b1;
         csr_index <= CSR_IMAGE_WIDTH;
         csr_data  <= w_val;
         @(posedge clock);
         cfg_width = w_val;
         @(negedge clock);
      end
      if (set_h) begin
         csr_write <= 1'b1;
         csr_index <= CSR_IMAGE_HEIGHT;
         csr_data  <= h_val;
         @(posedge clock);
         cfg_height = h_val;
         @(negedge clock);
      end
      csr_write <= 1'b0;
   endtask

   // ---------------------------------------------------------------------
   // Result side. Stalls a random number of cycles before each beat when idling
   // is on, then holds pop high until a result is taken and checks it field by field.
   // ---------------------------------------------------------------------
   initial begin : result_sink
      int stall;
      frame_stats_type want;
      wait (reset === 1'b0);
      @(negedge clock);
      forever begin
         stall = idle_on ? $urandom_range(0, 10) : 0;
         if (stall > 0) begin
            rsp_pop <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_pop <= 1'b1;
         do @(posedge clock); while (rsp_empty);
         if (frame_stats_due.size() == 0) begin
            note_mismatch($sformatf("result beat with none due: mean %0d sum %0d",
                                    rsp_mean_gradient, rsp_gradient_sum));
         end else begin
            want = frame_stats_due.pop_front();
            if (rsp_mean_gradient !== want.mean)
               note_mismatch($sformatf("mean_gradient expected %0d got %0d",
                                       want.mean, rsp_mean_gradient));
            if (rsp_gradient_sum !== want.sum)
               note_mismatch($sformatf("gradient_sum expected %0d got %0d",
                                       want.sum, rsp_gradient_sum));
         end
         @(negedge clock);
      end
   end

   // ---------------------------------------------------------------------
   // Directed frames at 2 x 2, one window each. Flat frames give zero; a
   // checkerboard of 0 and 255 gives the largest root, 255.0 in Q8.8, in
   // either polarity. The two one-sided steps are left to the tracker.
   // ---------------------------------------------------------------------
   pixel_row_type directed_rows [24] = '{
      '{8'h00, 1'b0, 16'd0, 38'd0}, '{8'h00, 1'b0, 16'd0, 38'd0},
      '{8'h00, 1'b0, 16'd0, 38'd0}, '{8'h00, 1'b1, 16'd0, 38'd0},
      '{8'hFF, 1'b0, 16'd0, 38'd0}, '{8'hFF, 1'b0, 16'd0, 38'd0},
      '{8'hFF, 1'b0, 16'd0, 38'd0}, '{8'hFF, 1'b1, 16'd0, 38'd0},
      '{8'h00, 1'b0, 16'd0, 38'd0}, '{8'hFF, 1'b0, 16'd0, 38'd0},
      '{8'hFF, 1'b0, 16'd0, 38'd0}, '{8'h00, 1'b1, 16'd65280, 38'd65280},
      '{8'hFF, 1'b0, 16'd0, 38'd0}, '{8'h00, 1'b0, 16'd0, 38'd0},
      '{8'h00, 1'b0, 16'd0, 38'd0}, '{8'hFF, 1'b1, 16'd65280, 38'd65280},
      '{8'h00, 1'b0, 16'd0, 38'd0}, '{8'hFF, 1'b0, 16'd0, 38'd0},
      '{8'h00, 1'b0, 16'd0, 38'd0}, '{8'h00, 1'b0, 16'd0, 38'd0},
      '{8'h00, 1'b0, 16'd0, 38'd0}, '{8'h00, 1'b0, 16'd0, 38'd0},
      '{8'hFF, 1'b0, 16'd0, 38'd0}, '{8'h00, 1'b0, 16'd0, 38'd0}
   };

   initial begin : pixel_source
      int unsigned first_random;
      int unsigned random_frames;
      int unsigned frame_count;
      logic [REG_W-1:0] w_val;
      logic [REG_W-1:0] h_val;
      frame_stats_type typed_stats;

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      program_size(1'b1, 12'd2, 1'b1, 12'd2);
      foreach (directed_rows[i]) begin
         typed_stats.mean = directed_rows[i].mean;
         typed_stats.sum  = directed_rows[i].sum;
         send_pixel(directed_rows[i].pixel, directed_rows[i].typed, typed_stats);
      end

      // Register extremes at the low end. Zero and one are raised to two in
      // either register. Idling is switched off for two of these frames so
      // that back-to-back beats occur.
      wait_idle();
      idle_on = 1'b0;
      program_size(1'b1, 12'd0, 1'b1, 12'd6);
      send_frame(TEX_NOISE);
      wait_idle();
      idle_on = 1'b1;
      program_size(1'b1, 12'd6, 1'b1, 12'd1);
      send_frame(TEX_BINARY);
      wait_idle();
      idle_on = 1'b0;
      program_size(1'b1, 12'd1, 1'b1, 12'd0);
      send_frame(TEX_SMOOTH);
      idle_on = 1'b1;

      // Random phases: a new frame size, then a few whole frames of mixed
      // texture. Most sizes are tiny so that many frames complete; now and
      // then a wider and flatter frame is drawn.
      first_random = pixels_sent;
      random_frames = 0;
      while (pixels_sent - first_random < RANDOM_PIXELS || random_frames < RANDOM_FRAMES) begin
         wait_idle();
         if ($urandom_range(0, 9) == 0) begin
            w_val = REG_W'($urandom_range(9, 40));
            h_val = REG_W'($urandom_range(0, 3));
         end else begin
            w_val = REG_W'($urandom_range(0, 7));
            h_val = REG_W'($urandom_range(0, 7));
         end
         idle_on = ($urandom_range(0, 3) != 0);
         program_size(1'b1, w_val, 1'b1, h_val);
         frame_count = $urandom_range(1, 4);
         repeat (frame_count) begin
            send_frame(texture_type'($urandom_range(0, 3)));
            random_frames++;
         end
      end

      idle_on = 1'b1;
      wait_idle();
      if (mismatches == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
